// File: src/irrc_pkg.sv
// shared widths, codes and sequencer states for the roll-rate controller
package irrc_pkg;

	localparam int MUL_A_W = 34;
	localparam int MUL_B_W = 24;
	localparam int PROD_W  = 58;

	localparam int CMD_LIMIT  = 4500;
	localparam int CD_PER_DEG = 100;

	localparam logic [16:0] ONE_Q16 = 17'h10000;

	localparam logic [1:0] MODE_PID    = 2'd0;
	localparam logic [1:0] MODE_ACTIVE = 2'd2;

	localparam logic [2:0] CFG_MODE  = 3'd0;
	localparam logic [2:0] CFG_ALPHA = 3'd1;
	localparam logic [2:0] CFG_LOOP  = 3'd2;
	localparam logic [2:0] CFG_GAIN  = 3'd3;
	localparam logic [2:0] CFG_INV   = 3'd4;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_MUL_RF,
		ST_MUL_AF,
		ST_MUL_ACC,
		ST_MUL_DES,
		ST_MUL_K,
		ST_ERR,
		ST_MUL_CMD,
		ST_CMD,
		ST_DONE
	} state_t;

endpackage

// File: src/irrc_mul.sv
// shared signed multiplier with registered product
module irrc_mul import irrc_pkg::*; (
	input  logic                      clk,
	input  logic signed [MUL_A_W-1:0] a,
	input  logic signed [MUL_B_W-1:0] b,
	output logic signed [PROD_W-1:0]  prod_q
);

	logic signed [PROD_W-1:0] prod_d;

	assign prod_d = PROD_W'(a) * PROD_W'(b);

	always_ff @(posedge clk) begin
		prod_q <= prod_d;
	end

endmodule

// File: src/indi_roll_rate_controller_top.sv
// roll-rate controller top: sequencer, state, config registers, output register
// a full INDI request steps from ST_MUL_RF through ST_CMD to ST_DONE,
// a passthrough or seeding request goes from ST_IDLE straight to ST_DONE
// requests are taken only in ST_IDLE; the INDI path makes six passes
// through the single shared multiplier, and ST_DONE waits while the output is stalled
// reset: config to defaults, filters unseeded, no result pending
module indi_roll_rate_controller_top import irrc_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [2:0]         cfg_index,
	input  logic [16:0]        cfg_data,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic signed [20:0] desired_rate,
	input  logic signed [20:0] measured_rate,
	input  logic signed [13:0] pid_command,
	input  logic               on_ground,
	input  logic               under_speed,
	output logic               out_valid,
	input  logic               out_stall,
	output logic signed [13:0] aileron_command,
	output logic               indi_engaged
);

	localparam int CMD_W = 43;
	localparam logic signed [PROD_W-1:0] HALF16 = PROD_W'(32768);
	localparam logic signed [PROD_W-1:0] HALF8  = PROD_W'(128);
	localparam logic signed [CMD_W-1:0]  HALF8C = CMD_W'(128);
	localparam logic signed [CMD_W-1:0]  LIM_HI = CMD_W'(CMD_LIMIT);
	localparam logic signed [CMD_W-1:0]  LIM_LO = -CMD_W'(CMD_LIMIT);
	localparam logic signed [13:0]       CMD_HI = 14'(CMD_LIMIT);

	function automatic logic signed [PROD_W-1:0] rnd16(input logic signed [PROD_W-1:0] x);
		rnd16 = (x + HALF16) >>> 16;
	endfunction

	function automatic logic signed [PROD_W-1:0] rnd8(input logic signed [PROD_W-1:0] x);
		rnd8 = (x + HALF8) >>> 8;
	endfunction

	state_t state_q, state_d;

	logic [1:0]  mode_q;
	logic [16:0] alpha_q, inv_q, alpha_eff, inv_eff;
	logic [9:0]  loop_q;
	logic [12:0] gain_q;

	logic signed [20:0] des_q, meas_q;
	logic signed [13:0] pid_q;
	logic               gnd_q, under_q;

	logic               seeded_q, arp_q;
	logic signed [20:0] rf_q, rf_new_q;
	logic signed [21:0] af_q, af_new_q;
	logic signed [13:0] last_q;

	logic signed [31:0]      accel_q;
	logic signed [26:0]      des_acc_q;
	logic signed [23:0]      k_q;
	logic signed [32:0]      err_q;
	logic signed [CMD_W-1:0] cmd_q;

	logic signed [MUL_A_W-1:0] mul_a;
	logic signed [MUL_B_W-1:0] mul_b;
	logic signed [PROD_W-1:0]  prod_q;

	logic signed [21:0] d_rf, d_acc, d_des;
	logic signed [22:0] d_af;
	logic signed [CMD_W-1:0] cmd_r;
	logic signed [13:0] lim, res;
	logic               req, act, path_pass, path_seed, out_free, done_fire, in_fire;

	logic               out_valid_q, indi_engaged_q;
	logic signed [13:0] aileron_q;

	irrc_mul u_mul (
		.clk    (clk),
		.a      (mul_a),
		.b      (mul_b),
		.prod_q (prod_q)
	);

	assign cfg_ready = 1'b1;
	assign alpha_eff = (alpha_q > ONE_Q16) ? ONE_Q16 : alpha_q;
	assign inv_eff   = (inv_q > ONE_Q16) ? ONE_Q16 : inv_q;

	// config writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q  <= MODE_PID;
			alpha_q <= 17'd7316;
			loop_q  <= 10'd400;
			gain_q  <= 13'd1024;
			inv_q   <= 17'd655;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				CFG_MODE:  mode_q  <= cfg_data[1:0];
				CFG_ALPHA: alpha_q <= cfg_data;
				CFG_LOOP:  loop_q  <= cfg_data[9:0];
				CFG_GAIN:  gain_q  <= cfg_data[12:0];
				CFG_INV:   inv_q   <= cfg_data;
				default: ;
			endcase
		end
	end

	assign d_rf  = 22'(meas_q) - 22'(rf_q);
	assign d_af  = 23'($signed({last_q, 8'd0})) - 23'(af_q);
	assign d_acc = 22'(rf_new_q) - 22'(rf_q);
	assign d_des = 22'(des_q) - 22'(rf_new_q);

	assign path_pass = (mode_q == MODE_PID);
	assign path_seed = !seeded_q || (loop_q == 10'd0);
	assign req       = (mode_q >= MODE_ACTIVE) && !gnd_q && !under_q;
	assign act       = req && arp_q && !path_pass && !path_seed;

	assign cmd_r = (cmd_q + HALF8C) >>> 8;
	always_comb begin
		if (cmd_r > LIM_HI)
			lim = CMD_HI;
		else if (cmd_r < LIM_LO)
			lim = -CMD_HI;
		else
			lim = 14'(cmd_r);
	end
	assign res = act ? lim : pid_q;

	assign out_free  = !out_valid_q || !out_stall;
	assign in_fire   = in_valid && !in_stall;
	assign done_fire = (state_q == ST_DONE) && out_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= ST_IDLE;
		else
			state_q <= state_d;
	end

	always_comb begin
		state_d  = state_q;
		in_stall = 1'b1;
		mul_a    = '0;
		mul_b    = '0;
		case (state_q)
			ST_IDLE: begin
				in_stall = 1'b0;
				if (in_valid) begin
					if (mode_q == MODE_PID || !seeded_q || loop_q == 10'd0)
						state_d = ST_DONE;
					else
						state_d = ST_MUL_RF;
				end
			end
			ST_MUL_RF: begin
				mul_a   = MUL_A_W'(d_rf);
				mul_b   = $signed(MUL_B_W'(alpha_eff));
				state_d = ST_MUL_AF;
			end
			ST_MUL_AF: begin
				mul_a   = MUL_A_W'(d_af);
				mul_b   = $signed(MUL_B_W'(alpha_eff));
				state_d = ST_MUL_ACC;
			end
			ST_MUL_ACC: begin
				mul_a   = MUL_A_W'(d_acc);
				mul_b   = $signed(MUL_B_W'(loop_q));
				state_d = ST_MUL_DES;
			end
			ST_MUL_DES: begin
				mul_a   = MUL_A_W'(d_des);
				mul_b   = $signed(MUL_B_W'(gain_q));
				state_d = ST_MUL_K;
			end
			ST_MUL_K: begin
				mul_a   = $signed(MUL_A_W'(inv_eff));
				mul_b   = MUL_B_W'(CD_PER_DEG);
				state_d = ST_ERR;
			end
			ST_ERR: begin
				state_d = ST_MUL_CMD;
			end
			ST_MUL_CMD: begin
				mul_a   = MUL_A_W'(err_q);
				mul_b   = k_q;
				state_d = ST_CMD;
			end
			ST_CMD: begin
				state_d = ST_DONE;
			end
			ST_DONE: begin
				if (out_free)
					state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// request capture and working registers
	always_ff @(posedge clk) begin
		if (in_fire) begin
			des_q   <= desired_rate;
			meas_q  <= measured_rate;
			pid_q   <= pid_command;
			gnd_q   <= on_ground;
			under_q <= under_speed;
		end
		case (state_q)
			ST_MUL_AF:  rf_new_q  <= 21'(PROD_W'(rf_q) + rnd16(prod_q));
			ST_MUL_ACC: af_new_q  <= 22'(PROD_W'(af_q) + rnd16(prod_q));
			ST_MUL_DES: accel_q   <= 32'(prod_q);
			ST_MUL_K:   des_acc_q <= 27'(rnd8(prod_q));
			ST_ERR: begin
				k_q   <= 24'(prod_q);
				err_q <= 33'(des_acc_q) - 33'(accel_q);
			end
			ST_CMD:     cmd_q     <= CMD_W'(PROD_W'(af_new_q) + rnd16(prod_q));
			default: ;
		endcase
	end

	// filter state
	always_ff @(posedge clk) begin
		if (done_fire && !path_pass) begin
			if (path_seed) begin
				rf_q   <= meas_q;
				af_q   <= 22'($signed({pid_q, 8'd0}));
				last_q <= pid_q;
			end else begin
				rf_q   <= rf_new_q;
				af_q   <= af_new_q;
				last_q <= res;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seeded_q <= 1'b0;
			arp_q    <= 1'b0;
		end else if (done_fire) begin
			if (path_pass) begin
				seeded_q <= 1'b0;
			end else if (path_seed) begin
				seeded_q <= 1'b1;
				arp_q    <= 1'b0;
			end else begin
				arp_q <= req;
			end
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (done_fire)
			out_valid_q <= 1'b1;
		else if (!out_stall)
			out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (done_fire) begin
			aileron_q      <= res;
			indi_engaged_q <= act;
		end
	end

	assign out_valid       = out_valid_q;
	assign aileron_command = aileron_q;
	assign indi_engaged    = indi_engaged_q;

	a_active_in_limits: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && indi_engaged |-> (aileron_command <= CMD_HI && aileron_command >= -CMD_HI))
		else $error("active command outside limits");

	a_active_needs_mode: assert property (@(posedge clk) disable iff (!arst_n)
		done_fire && act |-> mode_q >= MODE_ACTIVE && seeded_q)
		else $error("active command without active mode");

	a_accept_leaves_idle: assert property (@(posedge clk) disable iff (!arst_n)
		in_fire |=> state_q != ST_IDLE)
		else $error("request accepted but sequencer idle");

	a_no_result_lost: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(aileron_command))
		else $error("pending result overwritten");

endmodule
